>>> hw/rtl/met_pkg.sv
// shared types and constants for the multiplexed echo timer
`timescale 1ns / 1ps

package met_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_WAIT_LIMIT = 8'd1;

  localparam logic [7:0] MAX_TICKS_RST = 8'd200;
  localparam logic [7:0] ECHO_WAIT_LIMIT_RST = 8'd10;

  localparam logic FUNC_TASK = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] KIND_ECHO_END = 2'd0;
  localparam logic [1:0] KIND_SATURATED = 2'd1;
  localparam logic [1:0] KIND_NO_ECHO = 2'd2;

  localparam logic [7:0] NO_ECHO_CODE = 8'hff;

  typedef struct packed {
    logic       func;
    logic       echo_level;
    logic [1:0] query_sensor;
  } item_t;

  typedef struct packed {
    logic [3:0] trigger_levels;
    logic       measuring;
    logic       done_res;
    logic [1:0] done_sensor;
    logic [7:0] done_time;
    logic [1:0] done_kind;
    logic [7:0] queried_time;
  } result_t;

endpackage

>>> hw/rtl/met_core.sv
// measurement state and per-beat update for the echo timer
`timescale 1ns / 1ps

module met_core #(
  parameter int NUM_SENSORS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  met_pkg::item_t  item,
  input  logic [7:0]      max_ticks,
  input  logic [7:0]      echo_wait_limit,
  output met_pkg::result_t res
);
  import met_pkg::*;

  localparam logic [2:0] NS = 3'(NUM_SENSORS);

  logic [1:0] sensor_select, sensor_select_next;
  logic       in_progress, in_progress_next;
  logic       echo_seen, echo_seen_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] wait_count, wait_count_next;
  logic [3:0] trigger_state, trigger_state_next;
  logic [7:0] readings [4];
  logic [7:0] readings_next [4];

  logic [1:0] cur;
  logic [1:0] sel_adv;
  logic [3:0] bit_cur;
  logic [3:0] bit_adv;
  logic       done;
  logic [1:0] d_sensor;
  logic [7:0] d_time;
  logic [1:0] d_kind;

  assign cur = ({1'b0, sensor_select} >= NS) ? 2'd0 : sensor_select;
  assign sel_adv = (({1'b0, cur} + 3'd1) < NS) ? (cur + 2'd1) : 2'd0;
  assign bit_cur = 4'(4'b0001 << cur);
  assign bit_adv = 4'(4'b0001 << sel_adv);

  always_comb begin
    sensor_select_next = cur;
    in_progress_next = in_progress;
    echo_seen_next = echo_seen;
    tick_count_next = tick_count;
    wait_count_next = wait_count;
    trigger_state_next = trigger_state;
    readings_next = readings;
    done = 1'b0;
    d_sensor = 2'd0;
    d_time = 8'd0;
    d_kind = KIND_ECHO_END;
    if (item.func == FUNC_TASK) begin
      if (!in_progress) begin
        trigger_state_next = trigger_state & ~bit_cur;
        tick_count_next = 8'd0;
        wait_count_next = 8'd0;
        in_progress_next = 1'b1;
      end else begin
        trigger_state_next = trigger_state | bit_cur;
      end
    end else if (in_progress) begin
      if (echo_seen) begin
        if (item.echo_level) begin
          tick_count_next = tick_count + 8'd1;
          if (tick_count_next >= max_ticks) begin
            readings_next[cur] = max_ticks;
            done = 1'b1;
            d_sensor = cur;
            d_time = max_ticks;
            d_kind = KIND_SATURATED;
            in_progress_next = 1'b0;
            echo_seen_next = 1'b0;
            sensor_select_next = sel_adv;
          end
        end else begin
          readings_next[cur] = tick_count;
          done = 1'b1;
          d_sensor = cur;
          d_time = tick_count;
          d_kind = KIND_ECHO_END;
          in_progress_next = 1'b0;
          echo_seen_next = 1'b0;
          sensor_select_next = sel_adv;
          trigger_state_next = trigger_state | bit_adv;
        end
      end else if (item.echo_level) begin
        echo_seen_next = 1'b1;
      end else if (wait_count >= echo_wait_limit) begin
        readings_next[cur] = NO_ECHO_CODE;
        done = 1'b1;
        d_sensor = cur;
        d_time = NO_ECHO_CODE;
        d_kind = KIND_NO_ECHO;
        in_progress_next = 1'b0;
        echo_seen_next = 1'b0;
        trigger_state_next = trigger_state | bit_cur;
        sensor_select_next = sel_adv;
      end else begin
        wait_count_next = wait_count + 8'd1;
      end
    end
  end

  always_comb begin
    res.trigger_levels = trigger_state_next;
    res.measuring = in_progress_next;
    res.done_res = done;
    res.done_sensor = d_sensor;
    res.done_time = d_time;
    res.done_kind = d_kind;
    res.queried_time = readings_next[item.query_sensor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_select <= 2'd0;
      in_progress <= 1'b0;
      echo_seen <= 1'b0;
      tick_count <= 8'd0;
      wait_count <= 8'd0;
      trigger_state <= 4'hf;
      for (int i = 0; i < 4; i++) begin
        readings[i] <= 8'd0;
      end
    end else if (step) begin
      sensor_select <= sensor_select_next;
      in_progress <= in_progress_next;
      echo_seen <= echo_seen_next;
      tick_count <= tick_count_next;
      wait_count <= wait_count_next;
      trigger_state <= trigger_state_next;
      readings <= readings_next;
    end
  end

endmodule

>>> hw/rtl/multiplexed_echo_timer.sv
// top level of the round-robin ultrasonic echo timer
// an accepted beat is held in the input register, its result in the output register
// throughput: one beat per cycle while unstalled, set by the met_core state update
// a stalled output holds its beat while the input register keeps one more
// reset: synchronous, clears measurement state and readings, triggers high,
// registers back to max_ticks 200 and echo_wait_limit 10
`timescale 1ns / 1ps

module multiplexed_echo_timer #(
  parameter int NUM_SENSORS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // echo_level, query_sensor[1:0]
  input  logic [0:0]                      s_tuser,   // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // trigger_levels[3:0], measuring,
                                                     // done_sensor[1:0], done_time[7:0],
                                                     // queried_time[7:0]
  output logic [2:0]                      m_tuser,   // done_res, done_kind[1:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import met_pkg::*;

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_res;
  result_t    core_res;
  logic       advance;
  logic [7:0] max_ticks;
  logic [7:0] echo_wait_limit;

  assign advance = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ticks <= MAX_TICKS_RST;
      echo_wait_limit <= ECHO_WAIT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_TICKS: max_ticks <= cfg_data;
        REG_ECHO_WAIT_LIMIT: echo_wait_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func <= s_tuser[0];
      in_item.echo_level <= s_tdata[0];
      in_item.query_sensor <= s_tdata[2:1];
    end
  end

  met_core #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .item(in_item),
    .max_ticks(max_ticks),
    .echo_wait_limit(echo_wait_limit),
    .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {1'b0, out_res.queried_time, out_res.done_time, out_res.done_sensor,
                    out_res.measuring, out_res.trigger_levels};
  assign m_tuser = {out_res.done_kind, out_res.done_res};

endmodule

>>> hw/rtl/met_checker.sv
// port-level checks for the echo timer, bound to the top level
`timescale 1ns / 1ps

module met_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[14:5] == 10'd0 && m_tuser[2:1] == 2'd0)
    else $error("completion fields set without a finished measurement");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[4])
    else $error("still measuring after a finished measurement");

  a_no_echo_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && m_tuser[2:1] == 2'd2 |-> m_tdata[14:7] == 8'hff)
    else $error("no-echo reading is not 255");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:1] != 2'd3)
    else $error("unused completion kind");

endmodule

bind multiplexed_echo_timer met_checker u_met_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);

>>> test/multiplexed_echo_timer_tb.sv
// self-checking testbench for the multiplexed echo timer, scoreboard with its own predictor
`timescale 1ns / 1ps

module multiplexed_echo_timer_tb;
  import met_pkg::*;

  class echo_scoreboard;
    logic [7:0] max_ticks;
    logic [7:0] wait_limit;
    logic [1:0] sel;
    bit         busy;
    bit         seen;
    logic [7:0] ticks;
    logic [7:0] waits;
    logic [3:0] trig;
    logic [7:0] readings [4];
    result_t    expected_q [$];
    int         errors;
    int         checked;
    int         kind_count [3];

    function new();
      max_ticks  = MAX_TICKS_RST;
      wait_limit = ECHO_WAIT_LIMIT_RST;
      sel        = 2'd0;
      busy       = 1'b0;
      seen       = 1'b0;
      ticks      = 8'd0;
      waits      = 8'd0;
      trig       = 4'hf;
      foreach (readings[i]) readings[i] = 8'd0;
      errors     = 0;
      checked    = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MAX_TICKS) max_ticks = val;
      else if (idx == REG_ECHO_WAIT_LIMIT) wait_limit = val;
    endfunction

    // one accepted beat in, one expected result out
    function void note_item(item_t it);
      result_t r;
      r = '0;
      if (it.func == FUNC_TASK) begin
        if (!busy) begin
          trig[sel] = 1'b0;
          ticks     = 8'd0;
          waits     = 8'd0;
          busy      = 1'b1;
        end else begin
          trig[sel] = 1'b1;
        end
      end else if (busy) begin
        if (seen) begin
          if (it.echo_level) begin
            ticks = ticks + 8'd1;
            if (ticks >= max_ticks) begin
              readings[sel] = max_ticks;
              r.done_res    = 1'b1;
              r.done_sensor = sel;
              r.done_time   = max_ticks;
              r.done_kind   = KIND_SATURATED;
              busy          = 1'b0;
              seen          = 1'b0;
              sel           = sel + 2'd1;
            end
          end else begin
            readings[sel] = ticks;
            r.done_res    = 1'b1;
            r.done_sensor = sel;
            r.done_time   = ticks;
            r.done_kind   = KIND_ECHO_END;
            busy          = 1'b0;
            seen          = 1'b0;
            sel           = sel + 2'd1;
            trig[sel]     = 1'b1;
          end
        end else if (it.echo_level) begin
          seen = 1'b1;
        end else if (waits >= wait_limit) begin
          readings[sel] = NO_ECHO_CODE;
          r.done_res    = 1'b1;
          r.done_sensor = sel;
          r.done_time   = NO_ECHO_CODE;
          r.done_kind   = KIND_NO_ECHO;
          busy          = 1'b0;
          seen          = 1'b0;
          trig[sel]     = 1'b1;
          sel           = sel + 2'd1;
        end else begin
          waits = waits + 8'd1;
        end
      end
      r.trigger_levels = trig;
      r.measuring      = busy;
      r.queried_time   = readings[it.query_sensor];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.done_res && want.done_kind < 3) kind_count[want.done_kind]++;
      compare_field("trigger_levels", 8'(want.trigger_levels), 8'(got.trigger_levels));
      compare_field("measuring", 8'(want.measuring), 8'(got.measuring));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("done_sensor", 8'(want.done_sensor), 8'(got.done_sensor));
      compare_field("done_time", want.done_time, got.done_time);
      compare_field("done_kind", 8'(want.done_kind), 8'(got.done_kind));
      compare_field("queried_time", want.queried_time, got.queried_time);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int beats_sent = 0;
  int reg_writes = 0;

  multiplexed_echo_timer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    result_t got;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.trigger_levels = m_tdata[3:0];
        got.measuring      = m_tdata[4];
        got.done_sensor    = m_tdata[6:5];
        got.done_time      = m_tdata[14:7];
        got.queried_time   = m_tdata[22:15];
        got.done_res       = m_tuser[0];
        got.done_kind      = m_tuser[2:1];
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 60;
      end else if (stall_left == 0 && idle_on && !rst && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic func, logic echo, logic [1:0] query);
    item_t it;
    it.func         = func;
    it.echo_level   = echo;
    it.query_sensor = query;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'd0, query, echo};
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
    beats_sent++;
  endtask

  task automatic send_tick(logic echo);
    if ($urandom_range(0, 11) == 0)
      send_item(FUNC_TASK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    send_item(FUNC_TICK, echo, 2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    reg_writes++;
  endtask

  // one well-formed measurement with random content, sometimes preceded by noise
  task automatic run_measurement();
    int n;
    int hi;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)));
    end
    send_item(FUNC_TASK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) == 0)
      send_item(FUNC_TASK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 4) == 0) begin
      while (sb.busy && !sb.seen) send_tick(1'b0);
    end else begin
      n = $urandom_range(0, sb.wait_limit);
      repeat (n) if (sb.busy && !sb.seen) send_tick(1'b0);
    end
    if ($urandom_range(0, 4) == 0) hi = sb.max_ticks + 2;
    else hi = $urandom_range(0, (sb.max_ticks > 15) ? 15 : sb.max_ticks);
    if (sb.busy) send_tick(1'b1);
    while (sb.busy && hi > 0) begin
      send_tick(1'b1);
      hi--;
    end
    if (sb.busy) send_tick(1'b0);
  endtask

  task automatic run_phase(logic [7:0] max_val, logic [7:0] limit_val, bit pressure);
    int start;
    write_reg(REG_MAX_TICKS, max_val);
    write_reg(REG_ECHO_WAIT_LIMIT, limit_val);
    if (pressure) hold_req = 1'b1;
    start = beats_sent;
    while (beats_sent - start < 60) run_measurement();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings
    send_item(FUNC_TICK, 1'b1, 2'd0);
    send_item(FUNC_TASK, 1'b0, 2'd1);
    send_item(FUNC_TICK, 1'b0, 2'd2);
    send_item(FUNC_TASK, 1'b1, 2'd3);
    send_item(FUNC_TICK, 1'b1, 2'd0);
    send_item(FUNC_TICK, 1'b1, 2'd1);
    send_item(FUNC_TICK, 1'b1, 2'd2);
    send_item(FUNC_TICK, 1'b0, 2'd0);
    send_item(FUNC_TASK, 1'b0, 2'd0);

    // directed: tightest settings, unknown index ignored
    write_reg(REG_MAX_TICKS, 8'd1);
    write_reg(REG_ECHO_WAIT_LIMIT, 8'd0);
    write_reg(8'hfe, 8'd0);
    send_item(FUNC_TICK, 1'b0, 2'd1);
    send_item(FUNC_TASK, 1'b0, 2'd1);
    send_item(FUNC_TICK, 1'b1, 2'd0);
    send_item(FUNC_TICK, 1'b1, 2'd2);
    send_item(FUNC_TASK, 1'b0, 2'd2);
    send_item(FUNC_TICK, 1'b1, 2'd3);
    send_item(FUNC_TICK, 1'b0, 2'd3);
    send_item(FUNC_TASK, 1'b1, 2'd3);
    send_item(FUNC_TICK, 1'b0, 2'd0);
    send_item(FUNC_TICK, 1'b1, 2'd0);
    send_item(FUNC_TICK, 1'b0, 2'd1);
    send_item(FUNC_TICK, 1'b1, 2'd2);
    send_item(FUNC_TICK, 1'b0, 2'd3);

    // random phases
    run_phase(MAX_TICKS_RST, ECHO_WAIT_LIMIT_RST, 1'b0);
    run_phase(8'd254, 8'd255, 1'b1);
    run_phase(8'd1, 8'd0, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 8'($urandom_range(0, 20)), 1'b0);
    drain();
    idle_on = 1'b0;
    run_phase(8'($urandom_range(1, 30)), 8'($urandom_range(0, 20)), 1'b0);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d input beats, %0d results checked, %0d register writes",
             beats_sent, sb.checked, reg_writes);
    $display("measurements ended by echo fall %0d, by saturation %0d, without echo %0d",
             sb.kind_count[KIND_ECHO_END], sb.kind_count[KIND_SATURATED],
             sb.kind_count[KIND_NO_ECHO]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/met_pkg.sv
hw/rtl/met_core.sv
hw/rtl/multiplexed_echo_timer.sv
hw/rtl/met_checker.sv
test/multiplexed_echo_timer_tb.sv
